/* design/ssh_pkg.sv */
// Shared types, constants and helper functions for the stepper sweep-and-home block.
// No dependencies; every other design file refers to this package by scoped names.
package ssh_pkg;

  localparam int SWEEP_LEN_W = 16;
  localparam int CFG_DATA_W  = 16;
  localparam int CFG_INDEX_W = 1;
  localparam int PATTERN_W   = 4;
  localparam int PHASE_W     = 3;
  localparam int MODE_W      = 2;

  // Mode codes as they appear on the result channel.
  localparam logic [MODE_W-1:0] MODE_IDLE   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_SWEEP  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_RETURN = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_INDEX_W-1:0] CFG_SWEEP_LENGTH    = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_FIRST_DIRECTION = 1'd1;

  localparam logic [SWEEP_LEN_W-1:0] SWEEP_LENGTH_RESET    = 16'd2048;
  localparam logic                   FIRST_DIRECTION_RESET = 1'b1;

  typedef struct packed {
    logic [SWEEP_LEN_W-1:0] sweep_length;
    logic                   first_direction;
  } cfg_t;

  typedef struct packed {
    logic [PATTERN_W-1:0] coil_pattern;
    logic                 coil_written;
    logic                 homed;
    logic [MODE_W-1:0]    mode_now;
  } result_t;

  // Half-step coil drive table.
  function automatic logic [PATTERN_W-1:0] coil_lookup(input logic [PHASE_W-1:0] idx);
    logic [PATTERN_W-1:0] pat;
    case (idx)
      3'd0: pat = 4'h1;
      3'd1: pat = 4'h3;
      3'd2: pat = 4'h2;
      3'd3: pat = 4'h6;
      3'd4: pat = 4'h4;
      3'd5: pat = 4'hC;
      3'd6: pat = 4'h8;
      3'd7: pat = 4'h9;
      default: pat = 4'h0;
    endcase
    return pat;
  endfunction

  // Moves the table index one place, wrapping in both directions.
  function automatic logic [PHASE_W-1:0] move_index(input logic [PHASE_W-1:0] idx,
                                                    input logic rising);
    logic [PHASE_W-1:0] res;
    if (rising) begin
      res = idx + 3'd1;
    end else begin
      res = idx - 3'd1;
    end
    return res;
  endfunction

endpackage

/* design/ssh_cfg.sv */
// Configuration registers of the stepper sweep-and-home block.
// Depends on ssh_pkg for the register indexes, reset values and cfg_t.
module ssh_cfg (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [ssh_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [ssh_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  output ssh_pkg::cfg_t                    cfg
);

  logic [ssh_pkg::SWEEP_LEN_W-1:0] sweep_length_r;
  logic                            first_direction_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sweep_length_r    <= ssh_pkg::SWEEP_LENGTH_RESET;
      first_direction_r <= ssh_pkg::FIRST_DIRECTION_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        ssh_pkg::CFG_SWEEP_LENGTH:    sweep_length_r    <= cfg_wdata[ssh_pkg::SWEEP_LEN_W-1:0];
        ssh_pkg::CFG_FIRST_DIRECTION: first_direction_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  assign cfg.sweep_length    = sweep_length_r;
  assign cfg.first_direction = first_direction_r;

endmodule

/* design/ssh_step.sv */
// Mode sequencer: holds the motor state and computes one tick's result.
// Depends on ssh_pkg for mode codes, the coil table and the cfg_t/result_t structs.
module ssh_step #(
  parameter int COUNT_WIDTH = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              advance,
  input  logic              armed,
  input  ssh_pkg::cfg_t     cfg,
  output ssh_pkg::result_t  res
);

  localparam int LW = (COUNT_WIDTH > ssh_pkg::SWEEP_LEN_W) ? COUNT_WIDTH : ssh_pkg::SWEEP_LEN_W;

  typedef enum logic [ssh_pkg::MODE_W-1:0] {
    ST_IDLE   = ssh_pkg::MODE_IDLE,
    ST_SWEEP  = ssh_pkg::MODE_SWEEP,
    ST_RETURN = ssh_pkg::MODE_RETURN
  } mode_t;

  mode_t                          mode_r, mode_nxt;
  logic [COUNT_WIDTH-1:0]         count_r, count_nxt;
  logic                           dir_r, dir_nxt;
  logic [ssh_pkg::PHASE_W-1:0]    idx_r, idx_nxt;
  logic                           done_r, done_nxt;

  logic [LW-1:0]                  len_ext;
  logic [LW-1:0]                  max_ext;
  logic [COUNT_WIDTH-1:0]         limit;
  logic                           stepped;

  // A leg longer than the counter can hold is cut to the counter's maximum.
  assign len_ext = LW'(cfg.sweep_length);
  assign max_ext = LW'({COUNT_WIDTH{1'b1}});
  assign limit   = (len_ext > max_ext) ? max_ext[COUNT_WIDTH-1:0] : len_ext[COUNT_WIDTH-1:0];

  always_comb begin
    mode_nxt  = mode_r;
    count_nxt = count_r;
    dir_nxt   = dir_r;
    idx_nxt   = idx_r;
    done_nxt  = done_r;
    stepped   = 1'b0;
    res.coil_pattern = '0;
    res.coil_written = 1'b0;
    res.homed        = 1'b0;
    case (mode_r)
      ST_SWEEP: begin
        if (count_r < limit) begin
          count_nxt        = count_r + 1'b1;
          res.coil_pattern = ssh_pkg::coil_lookup(idx_r);
          res.coil_written = 1'b1;
          idx_nxt          = ssh_pkg::move_index(idx_r, dir_r);
        end else begin
          count_nxt = '0;
          dir_nxt   = ~dir_r;
          idx_nxt   = '0;
        end
        mode_nxt = armed ? ST_SWEEP : ST_RETURN;
      end
      ST_RETURN: begin
        // Same direction as the first leg: back out; otherwise finish the leg.
        if (dir_r == cfg.first_direction) begin
          if (count_r != '0) begin
            count_nxt = count_r - 1'b1;
            stepped   = 1'b1;
          end
        end else if (count_r < limit) begin
          count_nxt = count_r + 1'b1;
          stepped   = 1'b1;
        end
        if (stepped) begin
          res.coil_pattern = ssh_pkg::coil_lookup(idx_r);
          res.coil_written = 1'b1;
          idx_nxt          = ssh_pkg::move_index(idx_r, ~cfg.first_direction);
        end else begin
          done_nxt = 1'b1;
        end
        if (done_nxt) begin
          res.homed = 1'b1;
          mode_nxt  = ST_IDLE;
        end
      end
      default: begin
        done_nxt  = 1'b0;
        idx_nxt   = '0;
        count_nxt = '0;
        dir_nxt   = cfg.first_direction;
        mode_nxt  = armed ? ST_SWEEP : ST_IDLE;
      end
    endcase
    res.mode_now = mode_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= ST_SWEEP;
      count_r <= '0;
      dir_r   <= ssh_pkg::FIRST_DIRECTION_RESET;
      idx_r   <= '0;
      done_r  <= 1'b0;
    end else if (advance) begin
      mode_r  <= mode_nxt;
      count_r <= count_nxt;
      dir_r   <= dir_nxt;
      idx_r   <= idx_nxt;
      done_r  <= done_nxt;
    end
  end

endmodule

/* design/stepper_sweep_and_home.sv */
// Stepper half-step sweep sequencer with return-to-home, top level.
// An accepted item waits in the input register until the result register is free or draining.
// Throughput: one item per cycle while out_ready holds; the input and result registers
// each hold one item, and the sequencer state advances as an item moves between them.
// Reset (rst_n low, synchronous): sweep mode, count and phase zero, direction and
// configuration at their reset values, both registers empty.
module stepper_sweep_and_home #(
  parameter int COUNT_WIDTH = 16
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic                                 in_armed,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [ssh_pkg::PATTERN_W-1:0]        out_coil_pattern,
  output logic                                 out_coil_written,
  output logic                                 out_homed,
  output logic [ssh_pkg::MODE_W-1:0]           out_mode_now,
  input  logic                                 cfg_we,
  input  logic [ssh_pkg::CFG_INDEX_W-1:0]      cfg_index,
  input  logic [ssh_pkg::CFG_DATA_W-1:0]       cfg_wdata
);

  ssh_pkg::cfg_t    cfg;
  ssh_pkg::result_t res;
  ssh_pkg::result_t res_r;

  logic in_valid_r;
  logic armed_r;
  logic out_valid_r;
  logic advance;

  // An item moves into the result register whenever that register is free or draining.
  assign advance  = in_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !in_valid_r || advance;

  ssh_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  ssh_step #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_step (
    .clk     (clk),
    .rst_n   (rst_n),
    .advance (advance),
    .armed   (armed_r),
    .cfg     (cfg),
    .res     (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_ready) begin
        in_valid_r <= in_valid;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      armed_r <= in_armed;
    end
    if (advance) begin
      res_r <= res;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_coil_pattern = res_r.coil_pattern;
  assign out_coil_written = res_r.coil_written;
  assign out_homed        = res_r.homed;
  assign out_mode_now     = res_r.mode_now;

endmodule

/* design/ssh_checker.sv */
// Port-level checks for the stepper sweep-and-home block, bound to the top level.
// Depends on ssh_pkg for the mode codes.
module ssh_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [ssh_pkg::PATTERN_W-1:0] out_coil_pattern,
  input logic                          out_coil_written,
  input logic                          out_homed,
  input logic [ssh_pkg::MODE_W-1:0]    out_mode_now
);

  // A result that is not taken stays put.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_coil_pattern)
      && $stable(out_coil_written) && $stable(out_homed) && $stable(out_mode_now))
    else $error("result changed while stalled");

  // No step means the coils are not driven.
  a_idle_pattern: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_coil_written |-> out_coil_pattern == '0)
    else $error("coil pattern driven without a step");

  // A driven half-step pattern energizes one or two coils.
  a_pattern_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_coil_written |->
      $countones(out_coil_pattern) == 1 || $countones(out_coil_pattern) == 2)
    else $error("illegal coil pattern");

  // Homing always ends in idle.
  a_homed_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_homed |-> out_mode_now == ssh_pkg::MODE_IDLE)
    else $error("homed reported outside idle");

endmodule

bind stepper_sweep_and_home ssh_checker u_ssh_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .out_coil_pattern (out_coil_pattern),
  .out_coil_written (out_coil_written),
  .out_homed        (out_homed),
  .out_mode_now     (out_mode_now)
);

/* bench/testbench.sv */
// Self-checking bench for the stepper sweep-and-home sequencer: tick items in,
// coil results out, checked against an in-bench model of the sweep/return/idle modes.
// Depends on ssh_pkg and stepper_sweep_and_home.
`timescale 1ns / 100ps

module testbench;

  localparam int CYCLE_LIMIT = 200000;
  localparam int LONG_HOLD   = 120;
  localparam int SETTLE      = 8;

  // Half-step coil patterns, entry 0 in the low nibble.
  localparam logic [7:0][ssh_pkg::PATTERN_W-1:0] HALF_STEPS =
    {4'h9, 4'h8, 4'hC, 4'h4, 4'h6, 4'h2, 4'h3, 4'h1};

  // Leg length and first direction for each random phase, entry 0 first.
  localparam logic [7:0][ssh_pkg::SWEEP_LEN_W-1:0] LEG_PLAN =
    {16'd2048, 16'd7, 16'd2, 16'd5, 16'd65535, 16'd0, 16'd3, 16'd1};
  localparam logic [7:0] DIR_PLAN = 8'b1001_0110;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic in_armed = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [ssh_pkg::PATTERN_W-1:0] out_coil_pattern;
  logic out_coil_written;
  logic out_homed;
  logic [ssh_pkg::MODE_W-1:0] out_mode_now;
  logic cfg_we = 1'b0;
  logic [ssh_pkg::CFG_INDEX_W-1:0] cfg_index = ssh_pkg::CFG_SWEEP_LENGTH;
  logic [ssh_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;

  // Model copy of the sequencer registers and its configuration.
  logic [ssh_pkg::SWEEP_LEN_W-1:0] leg_len;
  logic first_dir;
  logic [ssh_pkg::MODE_W-1:0] seq_mode;
  logic [15:0] seq_count;
  logic seq_dir;
  logic [ssh_pkg::PHASE_W-1:0] seq_phase;
  logic seq_done;

  logic armed_flags[$];
  ssh_pkg::result_t ticks_due[$];
  int ticks_queued = 0;
  int ticks_taken = 0;
  int ticks_checked = 0;
  int bad_ticks = 0;
  int burst_left = 0;
  int gap_left = 0;
  int holds_asked = 0;
  int holds_taken = 0;
  int hold_left = 0;
  int pat_left = 0;
  logic [7:0] stall_pat = 8'hFF;
  int cycles = 0;

  stepper_sweep_and_home dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_armed(in_armed),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_coil_pattern(out_coil_pattern),
    .out_coil_written(out_coil_written),
    .out_homed(out_homed),
    .out_mode_now(out_mode_now),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Advances the model by one tick and returns the coil result it produces.
  function automatic ssh_pkg::result_t advance_sequencer(input logic armed);
    ssh_pkg::result_t r;
    logic stepped;
    r = '0;
    stepped = 1'b0;
    if (seq_mode == ssh_pkg::MODE_SWEEP) begin
      if (seq_count < leg_len) begin
        seq_count = seq_count + 16'd1;
        r.coil_pattern = HALF_STEPS[seq_phase];
        r.coil_written = 1'b1;
        seq_phase = seq_dir ? seq_phase + 3'd1 : seq_phase - 3'd1;
      end else begin
        seq_count = '0;
        seq_dir = ~seq_dir;
        seq_phase = '0;
      end
      seq_mode = armed ? ssh_pkg::MODE_SWEEP : ssh_pkg::MODE_RETURN;
    end else if (seq_mode == ssh_pkg::MODE_RETURN) begin
      // Undo the leg if it ran in the first direction, otherwise finish it.
      if (seq_dir == first_dir) begin
        if (seq_count != 16'd0) begin
          seq_count = seq_count - 16'd1;
          stepped = 1'b1;
        end
      end else if (seq_count < leg_len) begin
        seq_count = seq_count + 16'd1;
        stepped = 1'b1;
      end
      if (stepped) begin
        r.coil_pattern = HALF_STEPS[seq_phase];
        r.coil_written = 1'b1;
        seq_phase = first_dir ? seq_phase - 3'd1 : seq_phase + 3'd1;
      end else begin
        seq_done = 1'b1;
      end
      if (seq_done) begin
        r.homed = 1'b1;
        seq_mode = ssh_pkg::MODE_IDLE;
      end
    end else begin
      seq_done = 1'b0;
      seq_phase = '0;
      seq_count = '0;
      seq_dir = first_dir;
      seq_mode = armed ? ssh_pkg::MODE_SWEEP : ssh_pkg::MODE_IDLE;
    end
    r.mode_now = seq_mode;
    return r;
  endfunction

  task automatic offer(input logic armed, input int n);
    for (int i = 0; i < n; i++) begin
      armed_flags.push_back(armed);
    end
    ticks_queued += n;
  endtask

  // Mostly armed runs followed by a disarm, with some random noise runs.
  task automatic queue_random(input int n_items, input int leg);
    int span;
    int queued;
    int run;
    span = (leg > 12) ? 12 : leg;
    queued = 0;
    while (queued < n_items) begin
      if ($urandom_range(0, 9) < 8) begin
        run = $urandom_range(1, 3 * span + 2);
        offer(1'b1, run);
        queued += run;
        run = $urandom_range(1, span + 4);
        offer(1'b0, run);
        queued += run;
      end else begin
        run = $urandom_range(1, 6);
        offer($urandom_range(0, 1) == 1, run);
        queued += run;
      end
    end
  endtask

  task automatic write_reg(input logic [ssh_pkg::CFG_INDEX_W-1:0] idx,
                           input logic [ssh_pkg::CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == ssh_pkg::CFG_SWEEP_LENGTH) begin
      leg_len = val;
    end else begin
      first_dir = val[0];
    end
  endtask

  task automatic drain;
    while (ticks_taken < ticks_queued || ticks_checked < ticks_queued) begin
      @(posedge clk);
    end
  endtask

  initial begin
    leg_len = ssh_pkg::SWEEP_LENGTH_RESET;
    first_dir = ssh_pkg::FIRST_DIRECTION_RESET;
    seq_mode = ssh_pkg::MODE_SWEEP;
    seq_count = '0;
    seq_dir = ssh_pkg::FIRST_DIRECTION_RESET;
    seq_phase = '0;
    seq_done = 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Out of reset: a short sweep, a disarm that walks back home, then rearm.
    offer(1'b1, 4);
    offer(1'b0, 7);
    offer(1'b1, 1);
    drain();

    // Zero leg length: sweep only flips direction and return homes at once.
    write_reg(ssh_pkg::CFG_SWEEP_LENGTH, 16'd0);
    write_reg(ssh_pkg::CFG_FIRST_DIRECTION, 16'd0);
    offer(1'b1, 3);
    offer(1'b0, 3);
    offer(1'b1, 1);
    drain();

    for (int k = 0; k < 8; k++) begin
      write_reg(ssh_pkg::CFG_FIRST_DIRECTION, {15'd0, DIR_PLAN[k]});
      write_reg(ssh_pkg::CFG_SWEEP_LENGTH, LEG_PLAN[k]);
      queue_random(50, int'(LEG_PLAN[k]));
      // Hold the result side off for a while so the block backs up.
      if (k == 3) begin
        holds_asked++;
      end
      drain();
    end

    drain();
    repeat (SETTLE) @(posedge clk);
    if (bad_ticks == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // Sender: bursts of items with random gaps between them.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        ticks_due.push_back(advance_sequencer(in_armed));
        ticks_taken++;
      end
      if (!in_valid || in_ready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (armed_flags.size() != 0) begin
          in_armed <= armed_flags.pop_front();
          in_valid <= 1'b1;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(0, 12);
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 5);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: checks each accepted result and stalls on a rotating pattern.
  always @(posedge clk) begin
    ssh_pkg::result_t got;
    ssh_pkg::result_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        got = '{out_coil_pattern, out_coil_written, out_homed, out_mode_now};
        ticks_checked++;
        if (ticks_due.size() == 0) begin
          bad_ticks++;
          if (bad_ticks <= 10) begin
            $display("result with nothing expected: pattern %h written %b homed %b mode %0d",
                     got.coil_pattern, got.coil_written, got.homed, got.mode_now);
          end
        end else begin
          want = ticks_due.pop_front();
          if (got !== want) begin
            bad_ticks++;
            if (bad_ticks <= 10) begin
              $display("tick %0d: expected pattern %h written %b homed %b mode %0d, got %h %b %b %0d",
                       ticks_checked, want.coil_pattern, want.coil_written, want.homed,
                       want.mode_now, got.coil_pattern, got.coil_written, got.homed,
                       got.mode_now);
            end
          end
        end
      end
      if (holds_taken != holds_asked) begin
        holds_taken++;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        if (pat_left == 0) begin
          stall_pat = ($urandom_range(0, 3) == 0) ? 8'hFF : 8'($urandom);
          pat_left = 8 * $urandom_range(1, 4);
        end
        out_ready <= stall_pat[0];
        stall_pat = {stall_pat[0], stall_pat[7:1]};
        pat_left--;
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles == CYCLE_LIMIT) begin
      $display("FAILED: results differ");
      $finish;
    end
  end

endmodule
